// ===== rtl/core/lfopa_pkg.sv =====
`default_nettype none

package lfopa_pkg;

    // default configuration
    localparam int CHANNELS_DEF   = 6;
    localparam int PHASE_BITS_DEF = 24;

    // fixed field formats
    localparam int RATIO_W    = 24;   // Q8.16
    localparam int RATIO_FRAC = 16;
    localparam int SUS_W      = 8;    // unsigned 0.8 fraction of the phase (1/256 units)

    // per-item control view of the accumulator being advanced
    typedef struct packed {
        logic is_ref;
        logic is_glo;
        logic is_ch;
        logic muted;
        logic gate;
        logic rs;
        logic start;
        logic note_mode;
        logic run_cur;
        logic pend_cur;
    } t_ctl;

    // flag updates and write strobes produced by the update logic
    typedef struct packed {
        logic run_next;
        logic pend_next;
        logic act;
        logic head;
        logic wr_phase;
        logic wr_wave;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/core/lfo_phase_accumulator_resync.sv =====
`default_nettype none

// Channel   Dir  Handshake                      Content
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  one accumulator step request
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  new phase of that accumulator
// cfg       in   i_cfg_we                          note_mode_mask write
//
// One item per cycle unless the output stalls; an item passes the update stage and
// the output register. The phase memory is read on the accept edge and written as
// the item leaves the update stage; a read of the entry being written is forwarded.
// Reset (synchronous, i_rst_n low) clears all phases by valid bits, flags directly.
// A stalled output holds the update stage; the input still takes one item
// while the output register is full and the update stage is empty.
module lfo_phase_accumulator_resync #(
    parameter int CHANNELS   = lfopa_pkg::CHANNELS_DEF,
    parameter int PHASE_BITS = lfopa_pkg::PHASE_BITS_DEF,
    parameter int CW         = $clog2(CHANNELS + 2),
    parameter int IDW        = ((2 * PHASE_BITS + lfopa_pkg::RATIO_W + 4
                                 + lfopa_pkg::SUS_W + 7) / 8) * 8,
    parameter int ODW        = ((2 * PHASE_BITS + 2 + 7) / 8) * 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // slave side
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // tdata: increment, ratio, phase_offset, muted, gate_held, sustain_point,
    //        resync_request, note_start (zero padded)
    input  wire logic [IDW-1:0]      i_s_axis_tdata,
    // tuser: chan
    input  wire logic [CW-1:0]       i_s_axis_tuser,
    // master side
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // tdata: cycle_phase, wave_phase, note_active, head_reset (zero padded)
    output logic      [ODW-1:0]      o_m_axis_tdata,
    // tuser: chan_out
    output logic      [CW-1:0]       o_m_axis_tuser,
    // configuration
    input  wire logic                i_cfg_we,
    input  wire logic [CHANNELS-1:0] i_cfg_wdata
);

    localparam int RW      = lfopa_pkg::RATIO_W;
    localparam int SW      = lfopa_pkg::SUS_W;
    localparam int OFF_RAT = PHASE_BITS;
    localparam int OFF_OFS = PHASE_BITS + RW;
    localparam int OFF_MUT = 2 * PHASE_BITS + RW;
    localparam int OFF_GAT = OFF_MUT + 1;
    localparam int OFF_SUS = OFF_MUT + 2;
    localparam int OFF_RS  = OFF_SUS + SW;
    localparam int OFF_STA = OFF_RS + 1;
    localparam int WAW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CW-1:0] GLO_IDX = CW'(CHANNELS);
    localparam logic [CW-1:0] REF_IDX = CW'(CHANNELS + 1);

    // handshake
    logic s_acc;
    logic s1_adv;
    logic s1_fire;

    // configuration
    logic [CHANNELS-1:0] r_mask;

    // update stage
    logic                  r_s1_vld;
    logic [CW-1:0]         r_chan;
    logic [PHASE_BITS-1:0] r_inc;
    logic [RW-1:0]         r_ratio;
    logic [PHASE_BITS-1:0] r_offs;
    logic                  r_muted;
    logic                  r_gate;
    logic [SW-1:0]         r_sus;
    logic                  r_rs;
    logic                  r_start;

    // flags
    logic [CHANNELS-1:0]   r_running;
    logic [CHANNELS:0]     r_pending;
    logic [CHANNELS:0]     sel;

    // memory paths
    logic [CW-1:0]         parent_addr;
    logic [WAW-1:0]        wave_raddr;
    logic [WAW-1:0]        wave_waddr;
    logic [PHASE_BITS-1:0] own_rd;
    logic [PHASE_BITS-1:0] par_rd;
    logic [PHASE_BITS-1:0] wave_rd;

    lfopa_pkg::t_ctl       ctl;
    lfopa_pkg::t_res       res;
    logic [PHASE_BITS-1:0] cyc;
    logic [PHASE_BITS-1:0] wav;

    // output register
    logic                  r_o_vld;
    logic [CW-1:0]         r_o_chan;
    logic [PHASE_BITS-1:0] r_o_cyc;
    logic [PHASE_BITS-1:0] r_o_wav;
    logic                  r_o_act;
    logic                  r_o_head;

    // pipeline flow
    assign s1_adv          = !r_o_vld || i_m_axis_tready;
    assign s1_fire         = r_s1_vld && s1_adv;
    assign o_s_axis_tready = !r_s1_vld || s1_adv;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // hold the mode mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_wdata;
        end
    end

    // parent of the global clock is the reference, of a channel the global clock
    assign parent_addr = (i_s_axis_tuser == GLO_IDX) ? REF_IDX : GLO_IDX;
    assign wave_raddr  = (i_s_axis_tuser < CW'(CHANNELS)) ? WAW'(i_s_axis_tuser) : '0;
    assign wave_waddr  = WAW'(r_chan);

    lfopa_phase_mem #(
        .DEPTH (CHANNELS + 2),
        .AW    (CW),
        .DW    (PHASE_BITS)
    ) u_phase_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_re      (s_acc),
        .i_raddr_a (i_s_axis_tuser),
        .i_raddr_b (parent_addr),
        .i_we      (s1_fire && res.wr_phase),
        .i_waddr   (r_chan),
        .i_wdata   (cyc),
        .o_rdata_a (own_rd),
        .o_rdata_b (par_rd)
    );

    lfopa_wave_mem #(
        .DEPTH (CHANNELS),
        .AW    (WAW),
        .DW    (PHASE_BITS)
    ) u_wave_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (s_acc),
        .i_raddr (wave_raddr),
        .i_we    (s1_fire && res.wr_wave),
        .i_waddr (wave_waddr),
        .i_wdata (wav),
        .o_rdata (wave_rd)
    );

    // capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_chan  <= i_s_axis_tuser;
            r_inc   <= i_s_axis_tdata[0 +: PHASE_BITS];
            r_ratio <= i_s_axis_tdata[OFF_RAT +: RW];
            r_offs  <= i_s_axis_tdata[OFF_OFS +: PHASE_BITS];
            r_muted <= i_s_axis_tdata[OFF_MUT];
            r_gate  <= i_s_axis_tdata[OFF_GAT];
            r_sus   <= i_s_axis_tdata[OFF_SUS +: SW];
            r_rs    <= i_s_axis_tdata[OFF_RS];
            r_start <= i_s_axis_tdata[OFF_STA];
        end
    end

    // decode the accumulator in the update stage
    always_comb begin
        for (int k = 0; k <= CHANNELS; k++) begin
            sel[k] = (r_chan == CW'(k));
        end
    end

    always_comb begin
        ctl           = '0;
        ctl.is_ref    = (r_chan == REF_IDX);
        ctl.is_glo    = (r_chan == GLO_IDX);
        ctl.is_ch     = (r_chan < GLO_IDX);
        ctl.muted     = r_muted;
        ctl.gate      = r_gate;
        ctl.rs        = r_rs;
        ctl.start     = r_start;
        ctl.note_mode = |(r_mask & sel[CHANNELS-1:0]);
        ctl.run_cur   = |(r_running & sel[CHANNELS-1:0]);
        ctl.pend_cur  = |(r_pending & sel);
    end

    lfopa_update #(
        .PHASE_BITS (PHASE_BITS)
    ) u_update (
        .i_ctl      (ctl),
        .i_own      (own_rd),
        .i_parent   (par_rd),
        .i_wave_old (wave_rd),
        .i_inc      (r_inc),
        .i_ratio    (r_ratio),
        .i_offs     (r_offs),
        .i_sus      (r_sus),
        .o_res      (res),
        .o_cyc      (cyc),
        .o_wav      (wav)
    );

    // write back note and resync flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            r_pending <= '0;
        end else if (s1_fire) begin
            for (int k = 0; k < CHANNELS; k++) begin
                if (sel[k]) begin
                    r_running[k] <= res.run_next;
                end
            end
            for (int k = 0; k <= CHANNELS; k++) begin
                if (sel[k]) begin
                    r_pending[k] <= res.pend_next;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s1_adv) begin
            r_o_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_o_chan <= r_chan;
            r_o_cyc  <= cyc;
            r_o_wav  <= wav;
            r_o_act  <= res.act;
            r_o_head <= res.head;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tuser  = r_o_chan;
    assign o_m_axis_tdata  = ODW'({r_o_head, r_o_act, r_o_wav, r_o_cyc});

    // an accepted transaction occupies the update stage next cycle
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> r_s1_vld)
        else $error("accepted transaction did not reach the update stage");

    // a stalled update stage keeps its memory read data
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_adv) |=> ($stable(own_rd) && $stable(par_rd)))
        else $error("memory read data changed under a stall");

    // a head reset only comes from an idle note
    a_head_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_head) |-> !r_o_act)
        else $error("head reset reported on an active note");

    // clocks report no note and a wave phase equal to the cycle phase
    a_clock_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && (r_o_chan == GLO_IDX || r_o_chan == REF_IDX))
            |-> (!r_o_act && !r_o_head && r_o_wav == r_o_cyc))
        else $error("clock result carries note fields");

endmodule

`default_nettype wire

// ===== rtl/core/lfopa_phase_mem.sv =====
`default_nettype none

// Phase memory: one write port, two registered read ports (own and parent).
// Reads that hit the entry written on the same edge take the new data.
module lfopa_phase_mem #(
    parameter int DEPTH = lfopa_pkg::CHANNELS_DEF + 2,
    parameter int AW    = $clog2(lfopa_pkg::CHANNELS_DEF + 2),
    parameter int DW    = lfopa_pkg::PHASE_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr_a,
    input  wire logic [AW-1:0] i_raddr_b,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    output logic      [DW-1:0] o_rdata_a,
    output logic      [DW-1:0] o_rdata_b
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] r_vld;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // valid bits: entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // read ports with same-edge forwarding
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && i_waddr == i_raddr_a) begin
                o_rdata_a <= i_wdata;
            end else if (32'(i_raddr_a) < DEPTH && r_vld[i_raddr_a]) begin
                o_rdata_a <= mem[i_raddr_a];
            end else begin
                o_rdata_a <= '0;
            end
            if (i_we && i_waddr == i_raddr_b) begin
                o_rdata_b <= i_wdata;
            end else if (32'(i_raddr_b) < DEPTH && r_vld[i_raddr_b]) begin
                o_rdata_b <= mem[i_raddr_b];
            end else begin
                o_rdata_b <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lfopa_wave_mem.sv =====
`default_nettype none

// Wave phase memory: one write port, one registered read port with forwarding.
module lfopa_wave_mem #(
    parameter int DEPTH = lfopa_pkg::CHANNELS_DEF,
    parameter int AW    = $clog2(lfopa_pkg::CHANNELS_DEF),
    parameter int DW    = lfopa_pkg::PHASE_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] r_vld;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // valid bits: entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // read port with same-edge forwarding
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && i_waddr == i_raddr) begin
                o_rdata <= i_wdata;
            end else if (32'(i_raddr) < DEPTH && r_vld[i_raddr]) begin
                o_rdata <= mem[i_raddr];
            end else begin
                o_rdata <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lfopa_update.sv =====
`default_nettype none

// Next-phase logic for one accumulator: resync multiply-wrap, add modulo one,
// one-shot note handling and the wave phase offset.
module lfopa_update #(
    parameter int PHASE_BITS = lfopa_pkg::PHASE_BITS_DEF
) (
    input  wire lfopa_pkg::t_ctl                    i_ctl,
    input  wire logic [PHASE_BITS-1:0]              i_own,
    input  wire logic [PHASE_BITS-1:0]              i_parent,
    input  wire logic [PHASE_BITS-1:0]              i_wave_old,
    input  wire logic [PHASE_BITS-1:0]              i_inc,
    input  wire logic [lfopa_pkg::RATIO_W-1:0]      i_ratio,
    input  wire logic [PHASE_BITS-1:0]              i_offs,
    input  wire logic [lfopa_pkg::SUS_W-1:0]        i_sus,
    output lfopa_pkg::t_res                         o_res,
    output logic      [PHASE_BITS-1:0]              o_cyc,
    output logic      [PHASE_BITS-1:0]              o_wav
);

    localparam int PROD_W = PHASE_BITS + lfopa_pkg::RATIO_W;

    logic [PROD_W-1:0]     prod;
    logic [PHASE_BITS-1:0] rs_ph;
    logic [PHASE_BITS:0]   sum;
    logic [PHASE_BITS-1:0] add_ph;
    logic [PHASE_BITS-1:0] sus;
    logic [PHASE_BITS-1:0] ph;
    logic [PHASE_BITS-1:0] wv;
    logic                  pend_eff;
    logic                  run_eff;

    // resync: parent times Q8.16 ratio, drop the fraction, wrap modulo one
    assign prod  = PROD_W'(i_parent) * PROD_W'(i_ratio);
    assign rs_ph = prod[lfopa_pkg::RATIO_FRAC +: PHASE_BITS];

    // free step; the carry marks reaching one
    assign sum    = {1'b0, i_own} + {1'b0, i_inc};
    assign add_ph = sum[PHASE_BITS-1:0];
    assign sus    = {i_sus, {(PHASE_BITS - lfopa_pkg::SUS_W){1'b0}}};

    assign pend_eff = i_ctl.rs | i_ctl.pend_cur;
    assign run_eff  = i_ctl.start | i_ctl.run_cur;

    // select the new phase and flag updates
    always_comb begin
        o_res          = '0;
        o_res.run_next = run_eff;
        o_res.pend_next = pend_eff;
        ph             = '0;
        if (i_ctl.is_ref) begin
            ph             = add_ph;
            o_res.wr_phase = 1'b1;
        end else if (i_ctl.is_glo) begin
            ph              = pend_eff ? rs_ph : add_ph;
            o_res.pend_next = 1'b0;
            o_res.wr_phase  = 1'b1;
        end else if (i_ctl.is_ch) begin
            ph = i_own;
            if (!i_ctl.muted) begin
                o_res.wr_phase = 1'b1;
                o_res.wr_wave  = 1'b1;
                if (!i_ctl.note_mode) begin
                    o_res.pend_next = 1'b0;
                    ph = pend_eff ? rs_ph : add_ph;
                end else if (run_eff && sum[PHASE_BITS]) begin
                    // end of the one-shot: hold the phase
                    o_res.run_next = 1'b0;
                end else if (!run_eff) begin
                    // idle note: rewind and reset the wavetable head
                    o_res.head = 1'b1;
                    ph         = '0;
                end else if (i_ctl.gate && i_own <= sus && sum > {1'b0, sus}) begin
                    ph = sus;
                end else begin
                    ph = add_ph;
                end
            end
            o_res.act = o_res.run_next;
        end
    end

    // wave phase: offset for an advancing channel, held value when muted
    assign wv = ph + i_offs;

    always_comb begin
        o_cyc = ph;
        if (i_ctl.is_ch) begin
            o_wav = i_ctl.muted ? i_wave_old : wv;
        end else begin
            o_wav = ph;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/lfo_phase_accumulator_resync_tb.sv =====
`timescale 1ns / 1ps

module lfo_phase_accumulator_resync_tb;

    localparam int CH         = lfopa_pkg::CHANNELS_DEF;
    localparam int PB         = lfopa_pkg::PHASE_BITS_DEF;
    localparam int RATIO_W    = lfopa_pkg::RATIO_W;
    localparam int RATIO_FRAC = lfopa_pkg::RATIO_FRAC;
    localparam int SUS_W      = lfopa_pkg::SUS_W;
    localparam int CW     = $clog2(CH + 2);
    localparam int IDW    = ((2 * PB + RATIO_W + 4 + SUS_W + 7) / 8) * 8;
    localparam int ODW    = ((2 * PB + 2 + 7) / 8) * 8;
    localparam int GLO_CH = CH;
    localparam int REF_CH = CH + 1;
    localparam int MASK_MAX     = (1 << CH) - 1;
    localparam int PHASES       = 8;
    localparam int ITEMS_PER_PH = 119;

    typedef struct packed {
        logic [CW-1:0]      chan;
        logic [PB-1:0]      inc;
        logic [RATIO_W-1:0] ratio;
        logic [PB-1:0]      offs;
        logic               muted;
        logic               gate;
        logic [SUS_W-1:0]   sus;
        logic               rs;
        logic               start;
    } t_step_req;

    typedef struct packed {
        logic [CW-1:0] chan;
        logic [PB-1:0] cycle;
        logic [PB-1:0] wave;
        logic          active;
        logic          head;
    } t_phase_res;

    typedef struct packed {
        logic          set_mask;
        logic [CH-1:0] mask;
        t_step_req     req;
        logic          typed;
        t_phase_res    res;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [IDW-1:0]    i_s_axis_tdata;   // increment, ratio, phase_offset, muted, gate_held,
                                         // sustain_point, resync_request, note_start
    logic [CW-1:0]     i_s_axis_tuser;   // chan
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [ODW-1:0]    o_m_axis_tdata;   // cycle_phase, wave_phase, note_active, head_reset
    logic [CW-1:0]     o_m_axis_tuser;   // chan_out
    logic              i_cfg_we;
    logic [CH-1:0]     i_cfg_wdata;

    // predictor state
    logic [CH-1:0]     mode_mask;
    logic [PB-1:0]     phase_acc [0:CH+1];
    logic [PB-1:0]     wave_hold [0:CH-1];
    logic              note_run [0:CH-1];
    logic              resync_stage [0:CH];

    t_phase_res        due_results [$];
    int unsigned       n_errors;
    int unsigned       n_sent;
    int unsigned       n_checked;
    int unsigned       n_heads;
    int unsigned       n_active;
    int unsigned       n_masks;
    bit                src_burst;
    bit                snk_burst;

    // directed stimulus; typed results only where they follow at a glance
    t_dir_row dir_rows [25] = '{
        // reference extremes and wrap
        '{1'b0, 6'h00, '{REF_CH, 24'hFFFFFF, 24'h0, 24'h0, 0, 0, 8'h00, 0, 0},
          1'b1, '{REF_CH, 24'hFFFFFF, 24'hFFFFFF, 0, 0}},
        '{1'b0, 6'h00, '{REF_CH, 24'h000001, 24'h0, 24'h0, 0, 0, 8'h00, 0, 0},
          1'b1, '{REF_CH, 24'h000000, 24'h000000, 0, 0}},
        '{1'b0, 6'h00, '{REF_CH, 24'h800000, 24'h0, 24'h0, 0, 0, 8'h00, 0, 0},
          1'b1, '{REF_CH, 24'h800000, 24'h800000, 0, 0}},
        // global clock resync at the largest ratio, then wrap on add
        '{1'b0, 6'h00, '{GLO_CH, 24'h000000, 24'hFFFFFF, 24'h0, 0, 0, 8'h00, 1, 0},
          1'b1, '{GLO_CH, 24'hFFFF80, 24'hFFFF80, 0, 0}},
        '{1'b0, 6'h00, '{GLO_CH, 24'h000080, 24'h0, 24'h0, 0, 0, 8'h00, 0, 0},
          1'b1, '{GLO_CH, 24'h000000, 24'h000000, 0, 0}},
        // channel add with a wrapping offset, then muted with everything set
        '{1'b0, 6'h00, '{0, 24'h000100, 24'h0, 24'hFFFFFF, 0, 0, 8'h00, 0, 0},
          1'b1, '{0, 24'h000100, 24'h0000FF, 0, 0}},
        '{1'b0, 6'h00, '{0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1, 1, 8'hFF, 1, 1},
          1'b1, '{0, 24'h000100, 24'h0000FF, 1, 0}},
        // resync staged while muted takes effect now
        '{1'b0, 6'h00, '{0, 24'h000000, 24'h010000, 24'h123456, 0, 0, 8'h00, 0, 0},
          1'b1, '{0, 24'h000000, 24'h123456, 1, 0}},
        '{1'b0, 6'h00, '{5, 24'hFFFFFF, 24'h0, 24'h0, 0, 0, 8'h00, 0, 0},
          1'b1, '{5, 24'hFFFFFF, 24'hFFFFFF, 0, 0}},
        // all channels one-shot: idle head reset, start, sustain, end
        '{1'b1, 6'h3F, '{1, 24'h400000, 24'h0, 24'h000010, 0, 0, 8'h00, 0, 0},
          1'b1, '{1, 24'h000000, 24'h000010, 0, 1}},
        '{1'b0, 6'h00, '{1, 24'h400000, 24'h0, 24'h000010, 0, 0, 8'h00, 0, 1},
          1'b1, '{1, 24'h400000, 24'h400010, 1, 0}},
        '{1'b0, 6'h00, '{1, 24'h400000, 24'h0, 24'h0, 0, 1, 8'h60, 0, 0},
          1'b1, '{1, 24'h600000, 24'h600000, 1, 0}},
        '{1'b0, 6'h00, '{1, 24'h100000, 24'h0, 24'h0, 0, 1, 8'h60, 0, 0},
          1'b1, '{1, 24'h600000, 24'h600000, 1, 0}},
        '{1'b0, 6'h00, '{1, 24'h900000, 24'h0, 24'h0, 0, 0, 8'h00, 0, 0},
          1'b1, '{1, 24'hF00000, 24'hF00000, 1, 0}},
        '{1'b0, 6'h00, '{1, 24'h100000, 24'h0, 24'h0, 0, 0, 8'h00, 0, 0},
          1'b1, '{1, 24'hF00000, 24'hF00000, 0, 0}},
        '{1'b0, 6'h00, '{1, 24'h000005, 24'h0, 24'h0, 0, 0, 8'h00, 0, 0},
          1'b1, '{1, 24'h000000, 24'h000000, 0, 1}},
        // resync held pending in note mode, muted note
        '{1'b0, 6'h00, '{2, 24'hFFFFFF, 24'h0, 24'h0, 0, 0, 8'h00, 1, 1},
          1'b1, '{2, 24'hFFFFFF, 24'hFFFFFF, 1, 0}},
        '{1'b0, 6'h00, '{2, 24'h000001, 24'h0, 24'h0, 1, 0, 8'h00, 0, 0},
          1'b1, '{2, 24'hFFFFFF, 24'hFFFFFF, 1, 0}},
        '{1'b0, 6'h00, '{3, 24'h0F0000, 24'h0, 24'h0, 0, 1, 8'hFF, 0, 1},
          1'b0, '0},
        '{1'b0, 6'h00, '{3, 24'hFFFFFF, 24'h0, 24'h0, 0, 1, 8'hFF, 0, 0},
          1'b0, '0},
        // back to free-running: pending resync fires
        '{1'b1, 6'h00, '{2, 24'h000000, 24'hFFFFFF, 24'hABCDEF, 0, 0, 8'h00, 0, 0},
          1'b1, '{2, 24'h000000, 24'hABCDEF, 1, 0}},
        '{1'b0, 6'h00, '{REF_CH, 24'h000123, 24'h0, 24'h0, 0, 0, 8'h00, 1, 0},
          1'b1, '{REF_CH, 24'h800123, 24'h800123, 0, 0}},
        '{1'b0, 6'h00, '{GLO_CH, 24'h000000, 24'h018000, 24'h0, 0, 0, 8'h00, 1, 0},
          1'b1, '{GLO_CH, 24'hC001B4, 24'hC001B4, 0, 0}},
        '{1'b0, 6'h00, '{3, 24'h000000, 24'h008000, 24'h0, 0, 0, 8'h00, 1, 0},
          1'b1, '{3, 24'h6000DA, 24'h6000DA, 0, 0}},
        '{1'b0, 6'h00, '{4, 24'hABCDEF, 24'h123456, 24'h555555, 0, 1, 8'h80, 0, 0},
          1'b0, '0}
    };

    lfo_phase_accumulator_resync u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // wrapped product of a parent phase and a Q8.16 ratio
    function automatic logic [PB-1:0] ratio_phase(logic [PB-1:0] parent,
                                                  logic [RATIO_W-1:0] ratio);
        logic [PB+RATIO_W-1:0] prod;
        prod = (PB + RATIO_W)'(parent) * (PB + RATIO_W)'(ratio);
        return prod[RATIO_FRAC +: PB];
    endfunction

    // advance one accumulator and return its new phase
    function automatic t_phase_res advance_phase(t_step_req r);
        t_phase_res    o;
        logic [PB:0]   sum;
        logic [PB-1:0] ph;
        logic [PB-1:0] sus;
        o      = '0;
        o.chan = r.chan;
        sus    = {r.sus, {(PB - SUS_W){1'b0}}};
        if (r.chan == REF_CH) begin
            ph = phase_acc[REF_CH] + r.inc;
            phase_acc[REF_CH] = ph;
            o.cycle = ph;
            o.wave  = ph;
        end else if (r.chan == GLO_CH) begin
            if (r.rs)
                resync_stage[GLO_CH] = 1'b1;
            if (resync_stage[GLO_CH]) begin
                resync_stage[GLO_CH] = 1'b0;
                ph = ratio_phase(phase_acc[REF_CH], r.ratio);
            end else begin
                ph = phase_acc[GLO_CH] + r.inc;
            end
            phase_acc[GLO_CH] = ph;
            o.cycle = ph;
            o.wave  = ph;
        end else begin
            if (r.rs)
                resync_stage[r.chan] = 1'b1;
            if (r.start)
                note_run[r.chan] = 1'b1;
            ph = phase_acc[r.chan];
            if (r.muted) begin
                o.wave = wave_hold[r.chan];
            end else begin
                sum = {1'b0, ph} + {1'b0, r.inc};
                if (!mode_mask[r.chan]) begin
                    if (resync_stage[r.chan]) begin
                        resync_stage[r.chan] = 1'b0;
                        ph = ratio_phase(phase_acc[GLO_CH], r.ratio);
                    end else begin
                        ph = sum[PB-1:0];
                    end
                end else if (note_run[r.chan] && sum[PB]) begin
                    // note reached the end of its cycle: stop here
                    note_run[r.chan] = 1'b0;
                end else if (!note_run[r.chan]) begin
                    o.head = 1'b1;
                    ph = '0;
                end else if (r.gate && ph <= sus && sum > {1'b0, sus}) begin
                    ph = sus;
                end else begin
                    ph = sum[PB-1:0];
                end
                phase_acc[r.chan] = ph;
                o.wave = ph + r.offs;
                wave_hold[r.chan] = o.wave;
            end
            o.cycle  = ph;
            o.active = note_run[r.chan];
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                 $time, n_checked, what, got, want);
        n_errors++;
    endtask

    // send one transaction after a random gap, then record its expected result
    task automatic drive_item(t_step_req r, logic typed, t_phase_res want);
        int unsigned gap;
        t_phase_res  predicted;
        gap = src_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= r.chan;
        i_s_axis_tdata  <= IDW'({r.start, r.rs, r.sus, r.gate, r.muted,
                                 r.offs, r.ratio, r.inc});
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = advance_phase(r);
        due_results.push_back(typed ? want : predicted);
        n_sent++;
    endtask

    // drop valid and let everything in flight come out
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_mask(logic [CH-1:0] m);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mode_mask = m;
        n_masks++;
    endtask

    function automatic t_step_req random_step();
        t_step_req   r;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        r.chan = (sel < 7) ? CW'($urandom_range(0, CH - 1)) :
                 (sel < 9) ? CW'(GLO_CH) : CW'(REF_CH);
        // favor small steps so notes run through several ticks
        sel = $urandom_range(0, 7);
        case (sel)
            0:       r.inc = '0;
            1:       r.inc = '1;
            2, 3:    r.inc = PB'($urandom);
            default: r.inc = PB'($urandom_range(0, 24'h3FFFFF));
        endcase
        sel = $urandom_range(0, 9);
        r.ratio = (sel == 0) ? '0 : (sel == 1) ? '1 : RATIO_W'($urandom);
        r.offs  = PB'($urandom);
        r.muted = ($urandom_range(0, 9) == 0);
        r.gate  = 1'($urandom_range(0, 1));
        r.sus   = SUS_W'($urandom);
        r.rs    = ($urandom_range(0, 5) == 0);
        r.start = ($urandom_range(0, 7) == 0);
        return r;
    endfunction

    // result side: random stalls, compare each transaction with the oldest expectation
    initial begin
        int unsigned stall;
        t_phase_res  want;
        t_phase_res  got;
        i_m_axis_tready = 1'b0;
        snk_burst = 1'b0;
        // hold off until reset is released
        wait (i_rst_n === 1'b1);
        forever begin
            stall = snk_burst ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
            got.chan   = o_m_axis_tuser;
            got.cycle  = o_m_axis_tdata[PB-1:0];
            got.wave   = o_m_axis_tdata[2*PB-1:PB];
            got.active = o_m_axis_tdata[2*PB];
            got.head   = o_m_axis_tdata[2*PB+1];
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result, chan", 32'(got.chan), 32'hFFFFFFFF);
            end else begin
                want = due_results.pop_front();
                if (got.chan !== want.chan)
                    report_mismatch("chan_out", 32'(got.chan), 32'(want.chan));
                if (got.cycle !== want.cycle)
                    report_mismatch("cycle_phase", 32'(got.cycle), 32'(want.cycle));
                if (got.wave !== want.wave)
                    report_mismatch("wave_phase", 32'(got.wave), 32'(want.wave));
                if (got.active !== want.active)
                    report_mismatch("note_active", 32'(got.active), 32'(want.active));
                if (got.head !== want.head)
                    report_mismatch("head_reset", 32'(got.head), 32'(want.head));
                n_heads  += got.head;
                n_active += got.active;
            end
            n_checked++;
            if ($urandom_range(0, 39) == 0)
                snk_burst = !snk_burst;
        end
    end

    // stimulus
    initial begin
        logic [CH-1:0] m;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        mode_mask       = '0;
        src_burst       = 1'b0;
        n_errors = 0;
        n_sent   = 0;
        n_checked = 0;
        n_heads  = 0;
        n_active = 0;
        n_masks  = 0;
        for (int i = 0; i < CH + 2; i++)
            phase_acc[i] = '0;
        for (int i = 0; i < CH; i++) begin
            wave_hold[i] = '0;
            note_run[i]  = 1'b0;
        end
        for (int i = 0; i <= CH; i++)
            resync_stage[i] = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_mask) begin
                drain_results();
                load_mask(dir_rows[i].mask);
            end
            drive_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        end

        // random phases, each under its own mask, extremes first and last
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            m = (p == 0 || p == PHASES - 1) ? CH'(0) :
                (p == 1 || p == PHASES - 2) ? CH'(MASK_MAX) : CH'($urandom);
            load_mask(m);
            src_burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < ITEMS_PER_PH; k++)
                drive_item(random_step(), 1'b0, '0);
        end

        // wait out the last results
        i_s_axis_tvalid <= 1'b0;
        for (int w = 0; w < 5000 && due_results.size() != 0; w++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (due_results.size() != 0)
            report_mismatch("results never delivered", due_results.size(), 0);

        $display("covered %0d transactions over %0d mask settings, %0d results compared",
                 n_sent, n_masks, n_checked);
        $display("saw %0d head resets and %0d results with a running note",
                 n_heads, n_active);
        if (n_errors == 0) begin
            $display("lfo_phase_accumulator_resync_tb: done, clean");
        end else begin
            $display("lfo_phase_accumulator_resync_tb: done, errors");
        end
        $finish;
    end

    // hard stop if the handshakes hang
    initial begin
        #2_000_000;
        $display("lfo_phase_accumulator_resync_tb: done, errors");
        $finish;
    end

endmodule
